// ----- rtl/ffar_pkg.sv -----
// Shared types, constants and codes of the first-fit address range allocator.
package ffar_pkg;

  localparam int unsigned DEF_MAX_REGIONS = 64;
  localparam int unsigned DEF_PAGE_BYTES  = 4096;

  localparam logic [31:0] BASE_AT_RESET   = 32'h0040_0000;
  localparam logic [31:0] LENGTH_AT_RESET = 32'd2143289344;

  typedef enum logic {
    CFG_RANGE_BASE   = 1'b0,
    CFG_RANGE_LENGTH = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROUND,
    S_SRCH_RD,
    S_SRCH_EV,
    S_FINAL,
    S_INS_CHK,
    S_INS_EV,
    S_REL_RD,
    S_REL_EV,
    S_SHF_RD,
    S_SHF_WR,
    S_DONE
  } state_t;

endpackage

// ----- rtl/ffar_mem.sv -----
// Region table memory: one write port, one read port with registered data.
module ffar_mem
  import ffar_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_MAX_REGIONS,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/ffar_round.sv -----
// Page rounding unit: rounds the length up to whole pages using its byte residues modulo the page size.
module ffar_round
  import ffar_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = DEF_PAGE_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] length,
  output logic        done,
  output logic [32:0] size
);

  // Four bytes times residues below 2^17 stay well below 2^28.
  localparam int unsigned SW = 28;

  // Residue of 256^k modulo the page size, worked out at elaboration.
  function automatic logic [SW-1:0] byte_weight(input int unsigned k);
    longint unsigned w;
    w = 1;
    if (w >= PAGE_BYTES) w = 0;
    for (int unsigned j = 0; j < k; j++) begin
      w = w * 256;
      while (w >= PAGE_BYTES) w = w - PAGE_BYTES;
    end
    return SW'(w);
  endfunction

  localparam logic [SW-1:0] W0     = byte_weight(0);
  localparam logic [SW-1:0] W1     = byte_weight(1);
  localparam logic [SW-1:0] W2     = byte_weight(2);
  localparam logic [SW-1:0] W3     = byte_weight(3);
  localparam logic [SW-1:0] PAGE_W = SW'(PAGE_BYTES);

  logic [31:0]   len_r;
  logic [SW-1:0] sum_r, red_hi, red_lo;
  logic [1:0]    step_r;
  logic          busy_r, done_r;

  // The weighted byte sum is below 1024 pages, so ten conditional subtractions
  // of shifted pages leave the remainder; the five larger shifts come first, the five smaller after them.
  always_comb begin
    red_hi = sum_r;
    for (int j = 9; j >= 5; j--) begin
      if (red_hi >= (PAGE_W << j)) red_hi = red_hi - (PAGE_W << j);
    end
    red_lo = sum_r;
    for (int j = 4; j >= 0; j--) begin
      if (red_lo >= (PAGE_W << j)) red_lo = red_lo - (PAGE_W << j);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd2) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      len_r <= length;
    end else if (busy_r) begin
      case (step_r)
        2'd0: sum_r <= SW'(len_r[7:0]) * W0 + SW'(len_r[15:8]) * W1
                     + SW'(len_r[23:16]) * W2 + SW'(len_r[31:24]) * W3;
        2'd1: sum_r <= red_hi;
        default: sum_r <= red_lo;
      endcase
    end
  end

  assign done = done_r;
  assign size = (sum_r == '0) ? {1'b0, len_r}
              : {1'b0, len_r} + 33'(PAGE_W - sum_r);

endmodule

// ----- rtl/first_fit_address_range_allocator_top.sv -----
// Top level of the first-fit address range allocator: control sequencer and ports.
// An allocate rounds the length up to whole pages, walks the table in the search, checks the
// window, and shifts larger entries up on insertion; a release scans the table for the start
// and shifts later entries down.
// One transaction is in work at a time; each table entry costs a read state and an evaluate or
// write state, and a result still waiting in the output register holds the next one back.
// Reset (synchronous, rst_n low) empties the table and loads the default window.
module first_fit_address_range_allocator_top
  import ffar_pkg::*;
#(
  parameter int unsigned MAX_REGIONS = DEF_MAX_REGIONS,
  parameter int unsigned PAGE_BYTES  = DEF_PAGE_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] address, [63:32] length
  input  logic        in_tuser,   // [0] opcode
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [1:0] status, [33:2] granted_start, [39:34] zero
);

  localparam int unsigned AW = $clog2(MAX_REGIONS);
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_REGIONS);

  // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
  logic [31:0] range_base_r, range_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_base_r   <= BASE_AT_RESET;
      range_length_r <= LENGTH_AT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RANGE_BASE:   range_base_r   <= cfg_wdata;
        CFG_RANGE_LENGTH: range_length_r <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  state_t         state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [32:0]    start_r, start_nxt;     // candidate start, 33 bits so no wrap
  logic [32:0]    size_r, size_nxt;       // rounded size, up to 2^32
  logic [32:0]    limit_r, limit_nxt;     // range_base + range_length
  logic           desired_r, desired_nxt; // nonzero desired start was given
  logic [31:0]    addr_r, addr_nxt;
  logic           prev_valid_r, prev_valid_nxt;
  logic [32:0]    prev_end_r, prev_end_nxt;
  logic           pc_r, pc_nxt;           // previous entry equals current entry
  status_t        status_r, status_nxt;
  logic           out_valid_r, out_valid_nxt;
  status_t        out_status_r, out_status_nxt;
  logic [31:0]    out_start_r, out_start_nxt;
  logic           is_alloc_r;             // transaction in work is an allocate

  // Memory controls.
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        wr_data, rd_data;

  // Rounding unit controls.
  logic        rnd_start, rnd_done;
  logic [32:0] rnd_size;

  ffar_mem #(.DEPTH(MAX_REGIONS), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ffar_round #(.PAGE_BYTES(PAGE_BYTES)) u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (rnd_start),
    .length (in_tdata[63:32]),
    .done   (rnd_done),
    .size   (rnd_size)
  );

  logic accept;
  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  // Search evaluation of the entry just read.
  logic [32:0] s_start, s_end;
  logic [33:0] cand_end, skip_end;
  logic        last_entry, fit, brk_gap, moves, brk_limit, final_ok;

  always_comb begin
    s_start    = {1'b0, rd_data.start};
    s_end      = s_start + {1'b0, rd_data.size};
    cand_end   = {1'b0, start_r} + {1'b0, size_r};
    skip_end   = {1'b0, s_end} + {1'b0, size_r};
    last_entry = ({1'b0, idx_r} + {{AW{1'b0}}, 1'b1}) >= {{(AW+1-CW){1'b0}}, count_r};
    fit        = (s_start > start_r) && (cand_end <= {1'b0, s_start});
    // A fitting gap before this entry is taken when there is no previous region or it ends at or below start.
    brk_gap    = fit && (!prev_valid_r || (prev_end_r <= start_r));
    moves      = !desired_r && !(s_end <= start_r);
    brk_limit  = moves && (skip_end > {1'b0, limit_r});
    final_ok   = !(pc_r && (start_r < prev_end_r))
              && (cand_end <= {1'b0, limit_r})
              && (start_r >= {1'b0, range_base_r});
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (opcode_t'(in_tuser) == OP_ALLOC) begin
            state_nxt = (count_r >= MAX_C) ? S_DONE : S_ROUND;
          end else begin
            state_nxt = (count_r == '0) ? S_DONE : S_REL_RD;
          end
        end
      end
      S_ROUND: begin
        if (rnd_done) begin
          if (rnd_size == '0)        state_nxt = S_DONE;
          else if (count_r == '0)    state_nxt = S_FINAL;
          else                       state_nxt = S_SRCH_RD;
        end
      end
      S_SRCH_RD: state_nxt = S_SRCH_EV;
      S_SRCH_EV: begin
        if (brk_gap || brk_limit || last_entry) state_nxt = S_FINAL;
        else                                    state_nxt = S_SRCH_RD;
      end
      S_FINAL:   state_nxt = final_ok ? S_INS_CHK : S_DONE;
      S_INS_CHK: state_nxt = (idx_r == '0) ? S_DONE : S_INS_EV;
      S_INS_EV:  state_nxt = (rd_data.start <= start_r[31:0]) ? S_DONE : S_INS_CHK;
      S_REL_RD:  state_nxt = S_REL_EV;
      S_REL_EV: begin
        if (rd_data.start == addr_r) state_nxt = last_entry ? S_DONE : S_SHF_RD;
        else if (last_entry)         state_nxt = S_DONE;
        else                         state_nxt = S_REL_RD;
      end
      S_SHF_RD:  state_nxt = S_SHF_WR;
      S_SHF_WR: begin
        state_nxt = (({1'b0, idx_r} + {{AW-1{1'b0}}, 2'd2}) >=
                     {{(AW+1-CW){1'b0}}, count_r}) ? S_DONE : S_SHF_RD;
      end
      S_DONE:    state_nxt = (!out_valid_r || out_tready) ? S_IDLE : S_DONE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    start_nxt      = start_r;
    size_nxt       = size_r;
    limit_nxt      = limit_r;
    desired_nxt    = desired_r;
    addr_nxt       = addr_r;
    prev_valid_nxt = prev_valid_r;
    prev_end_nxt   = prev_end_r;
    pc_nxt         = pc_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    rnd_start      = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = rd_data;
    rd_en          = 1'b0;
    rd_addr        = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          addr_nxt       = in_tdata[31:0];
          desired_nxt    = (in_tdata[31:0] != '0);
          start_nxt      = (in_tdata[31:0] != '0) ? {1'b0, in_tdata[31:0]}
                                                  : {1'b0, range_base_r};
          limit_nxt      = {1'b0, range_base_r} + {1'b0, range_length_r};
          idx_nxt        = '0;
          prev_valid_nxt = 1'b0;
          pc_nxt         = 1'b0;
          if (opcode_t'(in_tuser) == OP_ALLOC) begin
            status_nxt = ST_FULL;
            rnd_start  = (count_r < MAX_C);
          end else begin
            status_nxt = ST_NOTFOUND;
          end
        end
      end
      S_ROUND: begin
        size_nxt   = rnd_size;
        status_nxt = ST_NOFIT;
      end
      S_SRCH_RD: rd_en = 1'b1;
      S_SRCH_EV: begin
        if (brk_gap) begin
          pc_nxt = 1'b0;
        end else begin
          prev_valid_nxt = 1'b1;
          prev_end_nxt   = s_end;
          pc_nxt         = 1'b1;
          if (moves) start_nxt = s_end;
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_FINAL: begin
        idx_nxt = count_r[AW-1:0];
        if (final_ok) status_nxt = ST_OK;
      end
      // Insertion walks down from the top, moving each larger entry up by one.
      S_INS_CHK: begin
        if (idx_r == '0) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = '{start: start_r[31:0], size: size_r[31:0]};
          count_nxt = count_r + CW'(1);
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r - AW'(1);
        end
      end
      S_INS_EV: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        if (rd_data.start <= start_r[31:0]) begin
          wr_data   = '{start: start_r[31:0], size: size_r[31:0]};
          count_nxt = count_r + CW'(1);
        end else begin
          wr_data = rd_data;
          idx_nxt = idx_r - AW'(1);
        end
      end
      S_REL_RD: rd_en = 1'b1;
      S_REL_EV: begin
        if (rd_data.start == addr_r) begin
          status_nxt = ST_OK;
          if (last_entry) count_nxt = count_r - CW'(1);
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      // Removal moves every later entry down by one.
      S_SHF_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_r + AW'(1);
      end
      S_SHF_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_data;
        idx_nxt = idx_r + AW'(1);
        if (({1'b0, idx_r} + {{AW-1{1'b0}}, 2'd2}) >= {{(AW+1-CW){1'b0}}, count_r}) begin
          count_nxt = count_r - CW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_start_nxt  = (status_r == ST_OK && is_alloc_r) ? start_r[31:0] : 32'd0;
        end
      end
      default: ;
    endcase
  end

  // Granted start: only successful allocations report it; a release reports zero.
  always_ff @(posedge clk) begin
    if (accept) is_alloc_r <= (opcode_t'(in_tuser) == OP_ALLOC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    start_r      <= start_nxt;
    size_r       <= size_nxt;
    limit_r      <= limit_nxt;
    desired_r    <= desired_nxt;
    addr_r       <= addr_nxt;
    prev_valid_r <= prev_valid_nxt;
    prev_end_r   <= prev_end_nxt;
    pc_r         <= pc_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_start_r, out_status_r};

endmodule

// ----- dv/first_fit_address_range_allocator_top_tb.sv -----
// Testbench for the first-fit address range allocator: directed table plus random traffic.
`timescale 1ns / 100ps

module first_fit_address_range_allocator_top_tb
  import ffar_pkg::*;
();

  localparam int unsigned NUM_REGIONS = DEF_MAX_REGIONS;
  localparam int unsigned PAGE_LEN    = DEF_PAGE_BYTES;
  localparam int unsigned RANDOM_REQS = 510;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  first_fit_address_range_allocator_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // A full clock period is 10 ns.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  typedef struct packed {
    status_t     status;
    logic [31:0] granted;
  } grant_t;

  // Shadow copy of the allocator state, kept in step with every accepted request.
  logic [31:0] win_base;
  logic [31:0] win_length;
  logic [31:0] shadow_start [NUM_REGIONS];
  logic [31:0] shadow_size  [NUM_REGIONS];
  int unsigned shadow_count;

  grant_t      pending_grants [$];
  int unsigned fail_count;

  // First-fit placement search on 64-bit values so that no window limit can wrap.
  function automatic bit place_region(input logic [63:0] desired, input logic [63:0] size,
                                      output logic [63:0] where);
    logic [63:0] start;
    logic [63:0] limit;
    logic [63:0] s_start;
    logic [63:0] s_end;
    int          prev;
    int          cur;
    start = (desired != 0) ? desired : {32'd0, win_base};
    limit = {32'd0, win_base} + {32'd0, win_length};
    prev  = -1;
    cur   = -1;
    where = '0;
    for (int i = 0; i < shadow_count; i++) begin
      s_start = {32'd0, shadow_start[i]};
      s_end   = s_start + {32'd0, shadow_size[i]};
      cur     = i;
      if (s_start > start && start + size <= s_start) begin
        if (prev < 0) break;
        if ({32'd0, shadow_start[prev]} + {32'd0, shadow_size[prev]} <= start) break;
      end
      prev = cur;
      if (desired == 0) begin
        if (s_end <= start) continue;
        start = s_end;
        if (start + size > limit) break;
      end
    end
    // If the walk ended on the last region, the candidate must clear its end.
    if (prev == cur && cur >= 0) begin
      if (start < {32'd0, shadow_start[cur]} + {32'd0, shadow_size[cur]}) return 1'b0;
    end
    if (start + size <= limit && start >= {32'd0, win_base}) begin
      where = start;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one request to the shadow table and returns the grant it should produce.
  function automatic grant_t apply_request(input opcode_t op, input logic [31:0] addr,
                                           input logic [31:0] len);
    grant_t      g;
    logic [63:0] size;
    logic [63:0] where;
    int unsigned pos;
    g.status  = ST_OK;
    g.granted = '0;
    if (op == OP_ALLOC) begin
      size = (({32'd0, len} + PAGE_LEN - 1) / PAGE_LEN) * PAGE_LEN;
      if (shadow_count >= NUM_REGIONS) begin
        g.status = ST_FULL;
      end else if (size == 0 || !place_region({32'd0, addr}, size, where)) begin
        g.status = ST_NOFIT;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_start[pos] <= where[31:0]) pos++;
        for (int k = shadow_count; k > pos; k--) begin
          shadow_start[k] = shadow_start[k-1];
          shadow_size[k]  = shadow_size[k-1];
        end
        shadow_start[pos] = where[31:0];
        shadow_size[pos]  = size[31:0];
        shadow_count++;
        g.granted = where[31:0];
      end
    end else begin
      g.status = ST_NOTFOUND;
      for (int i = 0; i < shadow_count; i++) begin
        if (shadow_start[i] == addr) begin
          for (int k = i; k + 1 < shadow_count; k++) begin
            shadow_start[k] = shadow_start[k+1];
            shadow_size[k]  = shadow_size[k+1];
          end
          shadow_count--;
          g.status = ST_OK;
          break;
        end
      end
    end
    return g;
  endfunction

  // Sends one request transaction after a random gap, then records its expected grant.
  // The request stays presented after its handshake until the next call or a drain.
  task automatic send_request(input opcode_t op, input logic [31:0] addr,
                              input logic [31:0] len, input bit typed,
                              input grant_t typed_grant);
    grant_t      g;
    int unsigned gap;
    gap = $urandom_range(0, 15);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {len, addr};
    do @(posedge clk); while (!in_tready);
    g = apply_request(op, addr, len);
    // Hand-typed rows cross-check the predictor as well as the block.
    if (typed && g != typed_grant) begin
      $error("table row: predicted status %0d granted_start %h, typed %0d %h",
             g.status, g.granted, typed_grant.status, typed_grant.granted);
      fail_count++;
    end
    pending_grants.push_back(g);
    @(negedge clk);
  endtask

  // Writes a window register; only called while the allocator is idle.
  task automatic write_window(input cfg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_RANGE_BASE) win_base = value;
    else win_length = value;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // The result side may hold tready low at random before it accepts each result.
  initial begin
    int unsigned hold;
    out_tready = 1'b0;
    forever begin
      hold = $urandom_range(0, 15);
      @(negedge clk);
      if (hold != 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_tvalid));
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_grants.size() == 0) begin
        $error("result with no request outstanding: %h", out_tdata);
        fail_count++;
      end else begin
        g = pending_grants.pop_front();
        if (out_tdata[1:0] != g.status) begin
          $error("status expected %0d actual %0d", g.status, out_tdata[1:0]);
          fail_count++;
        end
        if (out_tdata[33:2] != g.granted) begin
          $error("granted_start expected %h actual %h", g.granted, out_tdata[33:2]);
          fail_count++;
        end
      end
    end
  end

  typedef struct {
    opcode_t     op;
    logic [31:0] addr;
    logic [31:0] len;
    bit          typed;
    grant_t      g;
  } req_row_t;

  // Directed rows, run with the reset window of 0x400000 and 2143289344 bytes.
  req_row_t directed [] = '{
    '{OP_RELEASE, 32'h0040_0000, 32'd0,          1'b1, '{ST_NOTFOUND, 32'h0}},
    '{OP_ALLOC,   32'h0,         32'd0,          1'b1, '{ST_NOFIT, 32'h0}},
    '{OP_ALLOC,   32'h0,         32'd1,          1'b1, '{ST_OK, 32'h0040_0000}},
    '{OP_ALLOC,   32'h0,         32'd4096,       1'b0, '{ST_OK, 32'h0}},
    '{OP_ALLOC,   32'h0,         32'hFFFF_FFFF,  1'b1, '{ST_NOFIT, 32'h0}},
    '{OP_ALLOC,   32'hFFFF_F000, 32'd4096,       1'b1, '{ST_NOFIT, 32'h0}},
    '{OP_ALLOC,   32'h0000_1000, 32'd4096,       1'b1, '{ST_NOFIT, 32'h0}},
    '{OP_ALLOC,   32'h0040_0000, 32'd4096,       1'b0, '{ST_OK, 32'h0}},
    '{OP_ALLOC,   32'h1000_0000, 32'd8193,       1'b0, '{ST_OK, 32'h0}},
    '{OP_ALLOC,   32'h7FFF_F000, 32'd4096,       1'b0, '{ST_OK, 32'h0}},
    '{OP_ALLOC,   32'h0,         32'h0010_0000,  1'b0, '{ST_OK, 32'h0}},
    '{OP_RELEASE, 32'h0040_1000, 32'hFFFF_FFFF,  1'b0, '{ST_OK, 32'h0}},
    '{OP_ALLOC,   32'h0,         32'd100,        1'b0, '{ST_OK, 32'h0}},
    '{OP_RELEASE, 32'h1000_0000, 32'd0,          1'b0, '{ST_OK, 32'h0}},
    '{OP_RELEASE, 32'h1000_0000, 32'd0,          1'b1, '{ST_NOTFOUND, 32'h0}},
    '{OP_RELEASE, 32'hFFFF_FFFF, 32'd0,          1'b1, '{ST_NOTFOUND, 32'h0}}
  };

  initial begin
    opcode_t     op;
    logic [31:0] addr;
    logic [31:0] len;
    int unsigned pick;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_RANGE_BASE;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_ALLOC;
    fail_count = 0;
    win_base   = BASE_AT_RESET;
    win_length = LENGTH_AT_RESET;
    shadow_count = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i])
      send_request(directed[i].op, directed[i].addr, directed[i].len,
                   directed[i].typed, directed[i].g);

    // Fill the table completely to reach the table-full answer.
    for (int i = 0; i < NUM_REGIONS + 2; i++)
      send_request(OP_ALLOC, 32'h0, 32'd1, 1'b0, '0);
    wait_drained();

    // Random phases, each under its own window; a zero base allows a grant at address 0.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_window(CFG_RANGE_BASE, 32'h0);
          write_window(CFG_RANGE_LENGTH, 32'h0004_0000);
        end
        1: begin
          write_window(CFG_RANGE_BASE, 32'hFFFF_0000);
          write_window(CFG_RANGE_LENGTH, 32'hFFFF_FFFF);
        end
        2: begin
          write_window(CFG_RANGE_BASE, 32'hFFFF_FFFF);
          write_window(CFG_RANGE_LENGTH, 32'h0);
        end
        3: begin
          write_window(CFG_RANGE_BASE, 32'h0010_0000);
          write_window(CFG_RANGE_LENGTH, 32'h0008_0000);
        end
        4: begin
          write_window(CFG_RANGE_BASE, $urandom());
          write_window(CFG_RANGE_LENGTH, $urandom());
        end
        default: begin
          write_window(CFG_RANGE_BASE, BASE_AT_RESET);
          write_window(CFG_RANGE_LENGTH, LENGTH_AT_RESET);
        end
      endcase
      for (int n = 0; n < RANDOM_REQS / 6; n++) begin
        pick = $urandom_range(0, 9);
        len  = (pick < 8) ? $urandom_range(1, 4 * PAGE_LEN) : $urandom();
        addr = 32'h0;
        op   = OP_ALLOC;
        if (pick < 4) begin
          addr = 32'h0;
        end else if (pick < 6 && shadow_count != 0) begin
          // Mostly free live regions so the table churns.
          op   = OP_RELEASE;
          addr = shadow_start[$urandom_range(0, shadow_count - 1)];
        end else if (pick < 8) begin
          // Desired start near the window, page aligned or not.
          addr = win_base + ($urandom_range(0, 63) * PAGE_LEN)
               + (pick[0] ? $urandom_range(0, 15) : 0);
        end else begin
          op   = opcode_t'($urandom_range(0, 1));
          addr = $urandom();
        end
        send_request(op, addr, len, 1'b0, '0);
      end
      wait_drained();
    end

    if (fail_count == 0 && pending_grants.size() == 0) begin
      $display("PASS first_fit_address_range_allocator_top");
    end else begin
      $display("FAIL first_fit_address_range_allocator_top");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of about 600 transactions.
  initial begin
    #20ms;
    $display("FAIL first_fit_address_range_allocator_top");
    $finish;
  end

endmodule

// ----- first_fit_address_range_allocator_top.f -----
rtl/ffar_pkg.sv
rtl/ffar_mem.sv
rtl/ffar_round.sv
rtl/first_fit_address_range_allocator_top.sv
dv/first_fit_address_range_allocator_top_tb.sv
